// ----- rtl/core/ccgt_pkg.sv -----
package ccgt_pkg;

	localparam int REG_W = 17;
	localparam int OUT_W = 16;
	localparam int SUM_W = 18;
	localparam int QUO_W = 18;
	localparam int DVS_W = 17;
	localparam int DIV_CNT_W = $clog2(QUO_W + 1);
	localparam int LOG_W = 5;
	localparam int SCORE_W = 19;
	localparam int DEF_MAX_POPULATION = 65536;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SCAN  = 3'd1;
	localparam logic [2:0] PH_LEFT  = 3'd2;
	localparam logic [2:0] PH_RIGHT = 3'd3;
	localparam logic [2:0] PH_CHECK = 3'd4;

	localparam logic [1:0] ST_QUERY   = 2'd0;
	localparam logic [1:0] ST_FOUND   = 2'd1;
	localparam logic [1:0] ST_NONE    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	localparam logic [0:0] CFG_POPULATION_SIZE = 1'd0;
	localparam logic [0:0] CFG_CLUSTER_MAX     = 1'd1;

	typedef struct packed {
		logic [1:0]       status;
		logic [OUT_W-1:0] pool_first;
		logic [OUT_W-1:0] pool_last;
		logic [OUT_W-1:0] cluster_first;
		logic [OUT_W-1:0] cluster_last;
	} result_t;

	// microcode fields
	localparam int UPC_W = 3;

	localparam logic [2:0] OP_NOP      = 3'd0;
	localparam logic [2:0] OP_UPDATE   = 3'd1;
	localparam logic [2:0] OP_ADV      = 3'd2;
	localparam logic [2:0] OP_EMIT     = 3'd3;
	localparam logic [2:0] OP_DIV_LOAD = 3'd4;
	localparam logic [2:0] OP_START    = 3'd5;

	localparam logic [1:0] HOLD_NONE = 2'd0;
	localparam logic [1:0] HOLD_IN   = 2'd1;
	localparam logic [1:0] HOLD_DIV  = 2'd2;
	localparam logic [1:0] HOLD_OUT  = 2'd3;

	localparam logic [2:0] C_NEVER   = 3'd0;
	localparam logic [2:0] C_ALWAYS  = 3'd1;
	localparam logic [2:0] C_START   = 3'd2;
	localparam logic [2:0] C_FIN     = 3'd3;
	localparam logic [2:0] C_NOT_FIN = 3'd4;

	localparam logic [UPC_W-1:0] S_IDLE    = 3'd0;
	localparam logic [UPC_W-1:0] S_UPDATE  = 3'd1;
	localparam logic [UPC_W-1:0] S_ADV     = 3'd2;
	localparam logic [UPC_W-1:0] S_EMIT    = 3'd3;
	localparam logic [UPC_W-1:0] S_DIV_LD  = 3'd4;
	localparam logic [UPC_W-1:0] S_DIV_RUN = 3'd5;
	localparam logic [UPC_W-1:0] S_START   = 3'd6;
	localparam logic [UPC_W-1:0] S_SPARE   = 3'd7;

	typedef struct packed {
		logic [2:0]       op;
		logic [1:0]       hold;
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
	} uword_t;

	function automatic uword_t uw_mk(input logic [2:0] op, input logic [1:0] hold,
			input logic [2:0] cond, input logic [UPC_W-1:0] target);
		uword_t w;
		w.op = op;
		w.hold = hold;
		w.cond = cond;
		w.target = target;
		return w;
	endfunction

	// jump taken when cond holds, else fall through to the next step
	function automatic uword_t ucode(input logic [UPC_W-1:0] a);
		uword_t w;
		unique case (a)
			S_IDLE:    w = uw_mk(OP_NOP,      HOLD_IN,   C_START,   S_DIV_LD);
			S_UPDATE:  w = uw_mk(OP_UPDATE,   HOLD_NONE, C_FIN,     S_EMIT);
			S_ADV:     w = uw_mk(OP_ADV,      HOLD_NONE, C_NOT_FIN, S_ADV);
			S_EMIT:    w = uw_mk(OP_EMIT,     HOLD_OUT,  C_ALWAYS,  S_IDLE);
			S_DIV_LD:  w = uw_mk(OP_DIV_LOAD, HOLD_NONE, C_NEVER,   S_IDLE);
			S_DIV_RUN: w = uw_mk(OP_NOP,      HOLD_DIV,  C_NEVER,   S_IDLE);
			S_START:   w = uw_mk(OP_START,    HOLD_NONE, C_ALWAYS,  S_ADV);
			S_SPARE:   w = uw_mk(OP_NOP,      HOLD_NONE, C_ALWAYS,  S_IDLE);
		endcase
		return w;
	endfunction

	// count of powers of two below x
	function automatic logic [LOG_W-1:0] ceil_log2(input logic [REG_W-1:0] x);
		logic [LOG_W-1:0] c;
		c = '0;
		for (int i = 0; i < REG_W; i++) begin
			if ((REG_W'(1) << i) < x) begin
				c = c + LOG_W'(1);
			end
		end
		return c;
	endfunction

	function automatic result_t res_mk(input logic [1:0] st, input logic [OUT_W-1:0] a,
			input logic [OUT_W-1:0] b, input logic [OUT_W-1:0] c, input logic [OUT_W-1:0] d);
		result_t r;
		r.status = st;
		r.pool_first = a;
		r.pool_last = b;
		r.cluster_first = c;
		r.cluster_last = d;
		return r;
	endfunction

endpackage

// ----- rtl/core/ccgt_div.sv -----
module ccgt_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [ccgt_pkg::QUO_W-1:0]  dividend,
	input  logic [ccgt_pkg::DVS_W-1:0]  divisor,
	output logic                        busy,
	output logic [ccgt_pkg::QUO_W-1:0]  quotient
);

	logic [ccgt_pkg::QUO_W-1:0]     quo_q;
	logic [ccgt_pkg::DVS_W-1:0]     rem_q;
	logic [ccgt_pkg::DVS_W-1:0]     dvs_q;
	logic [ccgt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [ccgt_pkg::DVS_W:0]       rem_sh;
	logic [ccgt_pkg::DVS_W:0]       diff;
	logic                           ge;

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, quo_q[ccgt_pkg::QUO_W-1]};
		ge = (rem_sh >= {1'b0, dvs_q});
		diff = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= ccgt_pkg::DIV_CNT_W'(ccgt_pkg::QUO_W);
		end else if (busy) begin
			cnt_q <= cnt_q - ccgt_pkg::DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[ccgt_pkg::QUO_W-2:0], ge};
			rem_q <= ge ? diff[ccgt_pkg::DVS_W-1:0] : rem_sh[ccgt_pkg::DVS_W-1:0];
		end
	end

endmodule

// ----- rtl/core/consecutive_cluster_group_tester_core.sv -----
// Group-testing controller that locates one contiguous run of positives among
// population_size items by asking for pooled tests over index ranges.
// Configuration: write population_size (index 0) and cluster_max (index 1) on
// the cfg channel; cfg_ready is always high. Both reset to 1.
// Input channel (in_valid / in_stall): req_type 0 starts a search, req_type 1
// returns the answer to the last query in pool_positive. Each request yields
// exactly one response on the output channel (out_valid / out_stall): the next
// range to pool, the cluster found, no positives, or ignored when idle.
// A start request runs a serial divider for ceil(N/k); an answer request
// responds through the microcode steps of the search logic.
// One request is worked at a time; the next is taken once the previous
// response sits in the output register, even while that response is stalled.
// A stalled response holds in the output register; the sequencer waits at
// its emit step until the register frees. Reset returns the controller to
// idle with no response pending.
module consecutive_cluster_group_tester_core #(
	parameter int unsigned MAX_POPULATION = ccgt_pkg::DEF_MAX_POPULATION
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [0:0]                   cfg_index,
	input  logic [ccgt_pkg::REG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic                         pool_positive,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [ccgt_pkg::OUT_W-1:0]   pool_first,
	output logic [ccgt_pkg::OUT_W-1:0]   pool_last,
	output logic [ccgt_pkg::OUT_W-1:0]   cluster_first,
	output logic [ccgt_pkg::OUT_W-1:0]   cluster_last
);

	localparam int unsigned REG_MAX = (2 ** ccgt_pkg::REG_W) - 1;
	localparam int unsigned NMAX = (MAX_POPULATION < REG_MAX) ? MAX_POPULATION : REG_MAX;
	localparam int IW = $clog2(NMAX);
	localparam int NW = $clog2(NMAX + 1);
	localparam int SW = ccgt_pkg::SUM_W;
	localparam logic [ccgt_pkg::REG_W-1:0] NMAX_V = ccgt_pkg::REG_W'(NMAX);

	logic [ccgt_pkg::REG_W-1:0] pop_q;
	logic [ccgt_pkg::REG_W-1:0] kmax_q;

	logic [2:0]    phase_q, phase_d;
	logic          dense_q, dense_d;
	logic [IW-1:0] lo_q, lo_d;
	logic [IW-1:0] hi_q, hi_d;
	logic [SW-1:0] bs_q, bs_d;
	logic [IW-1:0] fpb_q, fpb_d;
	logic [IW-1:0] lpb_q, lpb_d;
	logic          any_q, any_d;
	logic [IW-1:0] left_q, left_d;
	logic          pos_q;

	logic [ccgt_pkg::UPC_W-1:0] upc_q, upc_d;
	ccgt_pkg::uword_t           uw;
	logic                       held;
	logic                       jump;
	logic                       fin;
	ccgt_pkg::result_t          res_d, res_q, out_q;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       emit_go;

	logic [NW-1:0]                    n_eff;
	logic [ccgt_pkg::REG_W-1:0]       k_eff;
	logic [SW-1:0]                    n18, k18;
	logic [IW-1:0]                    nm1;
	logic [IW-1:0]                    mid, mid_p1;
	logic [ccgt_pkg::QUO_W-1:0]       quo;
	logic                             div_busy;
	logic                             div_load;
	logic [ccgt_pkg::QUO_W-1:0]       dividend;
	logic [ccgt_pkg::SCORE_W-1:0]     s1, s2;

	function automatic logic [IW-1:0] blk_end(input logic [SW-1:0] s, input logic [SW-1:0] n,
			input logic [SW-1:0] k);
		logic [SW-1:0] e;
		e = s + k - SW'(1);
		return (e > n - SW'(1)) ? IW'(n - SW'(1)) : IW'(e);
	endfunction

	function automatic logic [ccgt_pkg::OUT_W-1:0] o16(input logic [IW-1:0] v);
		logic [SW-1:0] w;
		w = SW'(v);
		return w[ccgt_pkg::OUT_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= ccgt_pkg::REG_W'(1);
			kmax_q <= ccgt_pkg::REG_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ccgt_pkg::CFG_POPULATION_SIZE: pop_q <= cfg_data;
				ccgt_pkg::CFG_CLUSTER_MAX:     kmax_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (pop_q == '0) begin
			n_eff = NW'(1);
		end else if (pop_q > NMAX_V) begin
			n_eff = NW'(NMAX);
		end else begin
			n_eff = NW'(pop_q);
		end
		k_eff = (kmax_q == '0) ? ccgt_pkg::REG_W'(1) : kmax_q;
		n18 = SW'(n_eff);
		k18 = SW'(k_eff);
		nm1 = IW'(n_eff - NW'(1));
		mid = lo_q + ((hi_q - lo_q) >> 1);
		mid_p1 = mid + IW'(1);
		dividend = ccgt_pkg::QUO_W'(n18 + k18 - SW'(1));
		s1 = ccgt_pkg::SCORE_W'(quo)
			+ ccgt_pkg::SCORE_W'({ccgt_pkg::ceil_log2(k_eff), 1'b0});
		s2 = ccgt_pkg::SCORE_W'({ccgt_pkg::ceil_log2(ccgt_pkg::REG_W'(n_eff)), 1'b0});
	end

	ccgt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (dividend),
		.divisor  (k_eff),
		.busy     (div_busy),
		.quotient (quo)
	);

	// datapath: one search step per cycle while the sequencer is not held, selected by the current control word
	always_comb begin
		phase_d = phase_q;
		dense_d = dense_q;
		lo_d = lo_q;
		hi_d = hi_q;
		bs_d = bs_q;
		fpb_d = fpb_q;
		lpb_d = lpb_q;
		any_d = any_q;
		left_d = left_q;
		fin = 1'b0;
		res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_QUERY, '0, '0, '0, '0);
		unique case (uw.op)
			ccgt_pkg::OP_START: begin
				dense_d = (s1 <= s2);
				any_d = 1'b0;
				fpb_d = '0;
				lpb_d = '0;
				bs_d = '0;
				left_d = '0;
				lo_d = '0;
				hi_d = nm1;
				phase_d = (s1 <= s2) ? ccgt_pkg::PH_SCAN : ccgt_pkg::PH_LEFT;
			end
			ccgt_pkg::OP_UPDATE: begin
				unique case (phase_q)
					ccgt_pkg::PH_SCAN: begin
						if (pos_q) begin
							if (!any_q) begin
								fpb_d = IW'(bs_q);
							end
							any_d = 1'b1;
							lpb_d = IW'(bs_q);
						end
						bs_d = bs_q + k18;
					end
					ccgt_pkg::PH_LEFT: begin
						if (pos_q) begin
							hi_d = mid;
						end else begin
							lo_d = mid_p1;
						end
					end
					ccgt_pkg::PH_RIGHT: begin
						if (pos_q) begin
							lo_d = mid_p1;
						end else begin
							hi_d = mid;
						end
					end
					ccgt_pkg::PH_CHECK: begin
						phase_d = ccgt_pkg::PH_IDLE;
						fin = 1'b1;
						if (pos_q) begin
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_FOUND, '0, '0,
								o16(left_q), o16(lo_q));
						end else begin
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_NONE, '0, '0, '0, '0);
						end
					end
					default: begin
						phase_d = ccgt_pkg::PH_IDLE;
						fin = 1'b1;
						res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_IGNORED, '0, '0, '0, '0);
					end
				endcase
			end
			ccgt_pkg::OP_ADV: begin
				unique case (phase_q)
					ccgt_pkg::PH_SCAN: begin
						if (bs_q < n18) begin
							fin = 1'b1;
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_QUERY, bs_q[ccgt_pkg::OUT_W-1:0],
								o16(blk_end(bs_q, n18, k18)), '0, '0);
						end else if (!any_q) begin
							phase_d = ccgt_pkg::PH_IDLE;
							fin = 1'b1;
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_NONE, '0, '0, '0, '0);
						end else begin
							phase_d = ccgt_pkg::PH_LEFT;
							lo_d = fpb_q;
							hi_d = blk_end(SW'(fpb_q), n18, k18);
						end
					end
					ccgt_pkg::PH_LEFT: begin
						if (lo_q < hi_q) begin
							fin = 1'b1;
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_QUERY,
								dense_q ? o16(lo_q) : '0, o16(mid), '0, '0);
						end else begin
							left_d = lo_q;
							phase_d = ccgt_pkg::PH_RIGHT;
							if (dense_q) begin
								lo_d = lpb_q;
								hi_d = blk_end(SW'(lpb_q), n18, k18);
							end else begin
								hi_d = nm1;
							end
						end
					end
					ccgt_pkg::PH_RIGHT: begin
						if (lo_q < hi_q) begin
							fin = 1'b1;
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_QUERY, o16(mid_p1),
								dense_q ? o16(hi_q) : o16(nm1), '0, '0);
						end else if (!dense_q && left_q == nm1) begin
							phase_d = ccgt_pkg::PH_CHECK;
							fin = 1'b1;
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_QUERY, o16(nm1), o16(nm1),
								'0, '0);
						end else begin
							phase_d = ccgt_pkg::PH_IDLE;
							fin = 1'b1;
							res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_FOUND, '0, '0,
								o16(left_q), o16(lo_q));
						end
					end
					default: begin
						phase_d = ccgt_pkg::PH_IDLE;
						fin = 1'b1;
						res_d = ccgt_pkg::res_mk(ccgt_pkg::ST_IGNORED, '0, '0, '0, '0);
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		uw = ccgt_pkg::ucode(upc_q);
		in_stall = (uw.hold != ccgt_pkg::HOLD_IN);
		out_free = !out_valid_q || !out_stall;
		div_load = (uw.op == ccgt_pkg::OP_DIV_LOAD);
		emit_go = (uw.op == ccgt_pkg::OP_EMIT) && out_free;
		unique case (uw.hold)
			ccgt_pkg::HOLD_NONE: held = 1'b0;
			ccgt_pkg::HOLD_IN:   held = !in_valid;
			ccgt_pkg::HOLD_DIV:  held = div_busy;
			ccgt_pkg::HOLD_OUT:  held = !out_free;
		endcase
		unique case (uw.cond)
			ccgt_pkg::C_NEVER:   jump = 1'b0;
			ccgt_pkg::C_ALWAYS:  jump = 1'b1;
			ccgt_pkg::C_START:   jump = !req_type;
			ccgt_pkg::C_FIN:     jump = fin;
			ccgt_pkg::C_NOT_FIN: jump = !fin;
			default:             jump = 1'b0;
		endcase
		if (held) begin
			upc_d = upc_q;
		end else if (jump) begin
			upc_d = uw.target;
		end else begin
			upc_d = upc_q + ccgt_pkg::UPC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ccgt_pkg::S_IDLE;
			phase_q <= ccgt_pkg::PH_IDLE;
			dense_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
			bs_q <= '0;
			fpb_q <= '0;
			lpb_q <= '0;
			any_q <= 1'b0;
			left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			phase_q <= phase_d;
			dense_q <= dense_d;
			lo_q <= lo_d;
			hi_q <= hi_d;
			bs_q <= bs_d;
			fpb_q <= fpb_d;
			lpb_q <= lpb_d;
			any_q <= any_d;
			left_q <= left_d;
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pos_q <= pool_positive;
		end
		// hold the finished response until the output register frees
		if (fin) begin
			res_q <= res_d;
		end
		if (emit_go) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign pool_first = out_q.pool_first;
	assign pool_last = out_q.pool_last;
	assign cluster_first = out_q.cluster_first;
	assign cluster_last = out_q.cluster_last;

endmodule

// ----- tb/consecutive_cluster_group_tester_core_tb.sv -----
module consecutive_cluster_group_tester_core_tb;
	import ccgt_pkg::*;

	localparam int unsigned POP_LIMIT = DEF_MAX_POPULATION;
	localparam logic REQ_START  = 1'b0;
	localparam logic REQ_ANSWER = 1'b1;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 30;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [REG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic pool_positive;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [OUT_W-1:0] pool_first;
	logic [OUT_W-1:0] pool_last;
	logic [OUT_W-1:0] cluster_first;
	logic [OUT_W-1:0] cluster_last;

	consecutive_cluster_group_tester_core #(
		.MAX_POPULATION(POP_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.pool_positive(pool_positive),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.pool_first(pool_first),
		.pool_last(pool_last),
		.cluster_first(cluster_first),
		.cluster_last(cluster_last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// search predictor state
	logic [REG_W-1:0] reg_pop;
	logic [REG_W-1:0] reg_clu;
	logic [2:0]       srch_phase;
	logic             srch_dense;
	logic [15:0]      srch_lo;
	logic [15:0]      srch_hi;
	logic [16:0]      blk_at;
	logic [15:0]      blk_first;
	logic [15:0]      blk_last;
	logic             blk_any;
	logic [15:0]      edge_left;

	result_t expected_resp_q[$];
	int mismatch_count = 0;
	int reqs_sent = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int holdoff_asks = 0;
	int holdoff_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic int unsigned pop_clamp(int unsigned v);
		if (v == 0) return 1;
		if (v > POP_LIMIT) return POP_LIMIT;
		return v;
	endfunction

	function automatic int unsigned pop_eff();
		return pop_clamp(reg_pop);
	endfunction

	function automatic int unsigned clu_eff();
		return (reg_clu == 0) ? 1 : int'(reg_clu);
	endfunction

	function automatic int unsigned clog2_ceil(int unsigned x);
		int unsigned c;
		c = 0;
		while (c < 40 && (64'd1 << c) < 64'(x)) c++;
		return c;
	endfunction

	function automatic int unsigned blk_end(int unsigned s, int unsigned n, int unsigned k);
		int unsigned e;
		e = s + k - 1;
		return (e > n - 1) ? n - 1 : e;
	endfunction

	function automatic result_t make_resp(logic [1:0] st, int unsigned a, int unsigned b,
			int unsigned c, int unsigned d);
		result_t r;
		r.status = st;
		r.pool_first = a[15:0];
		r.pool_last = b[15:0];
		r.cluster_first = c[15:0];
		r.cluster_last = d[15:0];
		return r;
	endfunction

	// walk the search forward until a query or a final answer comes out
	function automatic result_t advance_search();
		int unsigned n, k, mid;
		result_t r;
		bit done;
		n = pop_eff();
		k = clu_eff();
		done = 1'b0;
		r = '0;
		while (!done) begin
			if (srch_phase == PH_SCAN) begin
				if (blk_at < n) begin
					r = make_resp(ST_QUERY, blk_at, blk_end(blk_at, n, k), 0, 0);
					done = 1'b1;
				end else if (!blk_any) begin
					srch_phase = PH_IDLE;
					r = make_resp(ST_NONE, 0, 0, 0, 0);
					done = 1'b1;
				end else begin
					srch_phase = PH_LEFT;
					srch_lo = blk_first;
					srch_hi = 16'(blk_end(blk_first, n, k));
				end
			end else if (srch_phase == PH_LEFT) begin
				if (srch_lo < srch_hi) begin
					mid = srch_lo + (srch_hi - srch_lo) / 2;
					r = make_resp(ST_QUERY, srch_dense ? int'(srch_lo) : 0, mid, 0, 0);
					done = 1'b1;
				end else begin
					edge_left = srch_lo;
					srch_phase = PH_RIGHT;
					if (srch_dense) begin
						srch_lo = blk_last;
						srch_hi = 16'(blk_end(blk_last, n, k));
					end else begin
						srch_lo = edge_left;
						srch_hi = 16'(n - 1);
					end
				end
			end else if (srch_phase == PH_RIGHT) begin
				if (srch_lo < srch_hi) begin
					mid = srch_lo + (srch_hi - srch_lo) / 2;
					r = make_resp(ST_QUERY, mid + 1, srch_dense ? int'(srch_hi) : n - 1, 0, 0);
				end else if (!srch_dense && edge_left == n - 1) begin
					srch_phase = PH_CHECK;
					r = make_resp(ST_QUERY, n - 1, n - 1, 0, 0);
				end else begin
					srch_phase = PH_IDLE;
					r = make_resp(ST_FOUND, 0, 0, edge_left, srch_lo);
				end
				done = 1'b1;
			end else begin
				srch_phase = PH_IDLE;
				r = make_resp(ST_IGNORED, 0, 0, 0, 0);
				done = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic result_t search_step(logic rt, logic pp);
		int unsigned n, k, s1, s2, mid;
		n = pop_eff();
		k = clu_eff();
		if (rt == REQ_START) begin
			s1 = (n + k - 1) / k + 2 * clog2_ceil(k);
			s2 = 2 * clog2_ceil(n);
			srch_dense = (s1 <= s2);
			blk_any = 1'b0;
			blk_first = '0;
			blk_last = '0;
			blk_at = '0;
			edge_left = '0;
			srch_lo = '0;
			srch_hi = 16'(n - 1);
			srch_phase = srch_dense ? PH_SCAN : PH_LEFT;
			return advance_search();
		end
		case (srch_phase)
			PH_SCAN: begin
				if (pp) begin
					if (!blk_any) blk_first = blk_at[15:0];
					blk_any = 1'b1;
					blk_last = blk_at[15:0];
				end
				blk_at = 17'(blk_at + k);
			end
			PH_LEFT: begin
				mid = srch_lo + (srch_hi - srch_lo) / 2;
				if (pp) srch_hi = 16'(mid);
				else srch_lo = 16'(mid + 1);
			end
			PH_RIGHT: begin
				mid = srch_lo + (srch_hi - srch_lo) / 2;
				if (pp) srch_lo = 16'(mid + 1);
				else srch_hi = 16'(mid);
			end
			PH_CHECK: begin
				srch_phase = PH_IDLE;
				if (pp) return make_resp(ST_FOUND, 0, 0, edge_left, srch_lo);
				return make_resp(ST_NONE, 0, 0, 0, 0);
			end
			default: begin
				srch_phase = PH_IDLE;
				return make_resp(ST_IGNORED, 0, 0, 0, 0);
			end
		endcase
		return advance_search();
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// response checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_resp_q.size() == 0) begin
				report_mismatch($sformatf("unexpected response status %0d", status));
			end else begin
				want = expected_resp_q.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d", status, want.status));
				if (pool_first !== want.pool_first)
					report_mismatch($sformatf("pool_first got %0d want %0d",
						pool_first, want.pool_first));
				if (pool_last !== want.pool_last)
					report_mismatch($sformatf("pool_last got %0d want %0d",
						pool_last, want.pool_last));
				if (cluster_first !== want.cluster_first)
					report_mismatch($sformatf("cluster_first got %0d want %0d",
						cluster_first, want.cluster_first));
				if (cluster_last !== want.cluster_last)
					report_mismatch($sformatf("cluster_last got %0d want %0d",
						cluster_last, want.cluster_last));
			end
		end
	end

	// receiver: random stall, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (holdoff_seen != holdoff_asks) begin
			holdoff_seen <= holdoff_asks;
			hold_left <= HOLDOFF_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_req(input logic rt, input logic pp, output result_t predicted);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		pool_positive <= pp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = search_step(rt, pp);
		expected_resp_q = {expected_resp_q, predicted};
		reqs_sent++;
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (expected_resp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [REG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_POPULATION_SIZE) reg_pop = val;
		else reg_clu = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [REG_W-1:0] n, input logic [REG_W-1:0] k);
		wait_results_done();
		write_reg(CFG_POPULATION_SIZE, n);
		write_reg(CFG_CLUSTER_MAX, k);
	endtask

	task automatic pick_config();
		int unsigned n, ne, k, lo, hi, sel;
		sel = $urandom_range(99);
		if (sel < 70) n = $urandom_range(64, 2);
		else if (sel < 84) n = $urandom_range(4096, 65);
		else if (sel < 90) n = $urandom_range(1);
		else if (sel < 95) n = $urandom_range(1) ? 65536 : 65535;
		else n = $urandom_range(131071, 65537);
		ne = pop_clamp(n);
		sel = $urandom_range(99);
		if (sel < 45) begin
			// block sizes near N/4..N/2 tend to pick the dense scan
			lo = (ne / 4 > 0) ? ne / 4 : 1;
			hi = ne / 2 + 1;
			k = $urandom_range(hi, lo);
		end else if (sel < 85) begin
			k = $urandom_range(ne, 1);
		end else if (sel < 92) begin
			k = 0;
		end else begin
			k = $urandom_range(131071, ne);
		end
		configure(17'(n), 17'(k));
	endtask

	// one search against a lab holding at most one cluster, with optional noise
	task automatic run_search(input int lie_pct);
		result_t got;
		int unsigned n, k, clen, cstart, cend;
		bit present;
		logic pp;
		int steps;
		n = pop_eff();
		k = clu_eff();
		present = ($urandom_range(99) < 85);
		clen = $urandom_range((k < n) ? k : n, 1);
		cstart = $urandom_range(n - clen, 0);
		cend = cstart + clen - 1;
		send_req(REQ_START, 1'($urandom_range(1)), got);
		steps = 0;
		while (got.status == ST_QUERY && steps < 80) begin
			if ($urandom_range(99) < 3) begin
				// abandon and restart mid-search
				send_req(REQ_START, 1'($urandom_range(1)), got);
			end else begin
				pp = present && (got.pool_first <= cend) && (got.pool_last >= cstart);
				if ($urandom_range(99) < lie_pct) pp = 1'($urandom_range(1));
				send_req(REQ_ANSWER, pp, got);
			end
			steps++;
		end
	endtask

	task automatic test_idle_answers();
		result_t got;
		send_req(REQ_ANSWER, 1'b0, got);
		send_req(REQ_ANSWER, 1'b1, got);
	endtask

	task automatic test_single_item();
		result_t got;
		// reset registers give one item: only the final check of item 0 remains
		send_req(REQ_START, 1'b1, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_START, 1'b0, got);
		send_req(REQ_ANSWER, 1'b0, got);
	endtask

	task automatic test_zero_registers();
		result_t got;
		configure(17'd0, 17'd0);
		send_req(REQ_START, 1'b0, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_ANSWER, 1'b1, got);
	endtask

	task automatic test_oversized_restart();
		result_t got;
		configure(17'h1FFFF, 17'd16384);
		send_req(REQ_START, 1'b1, got);
		send_req(REQ_ANSWER, 1'b0, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_START, 1'b0, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_ANSWER, 1'b0, got);
	endtask

	task automatic test_dense_scan();
		result_t got;
		configure(17'd4, 17'd2);
		send_req(REQ_START, 1'b0, got);
		send_req(REQ_ANSWER, 1'b0, got);
		send_req(REQ_ANSWER, 1'b0, got);
		send_req(REQ_START, 1'b1, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_ANSWER, 1'b1, got);
		send_req(REQ_ANSWER, 1'b1, got);
	endtask

	task automatic test_random_searches(input int src_pct, input int sink_pct, input int budget);
		result_t got;
		int stop_at, until_cfg;
		wait_results_done();
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		stop_at = reqs_sent + budget;
		until_cfg = 0;
		while (reqs_sent < stop_at) begin
			if (until_cfg == 0) begin
				pick_config();
				until_cfg = $urandom_range(4, 1);
			end
			run_search(($urandom_range(99) < 12) ? 30 : 0);
			if ($urandom_range(99) < 8)
				send_req(REQ_ANSWER, 1'($urandom_range(1)), got);
			until_cfg--;
		end
	endtask

	task automatic test_backpressure();
		wait_results_done();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		configure(17'd64, 17'd32);
		// hold the receiver off while requests keep coming, so the block fills
		holdoff_asks <= holdoff_asks + 1;
		repeat (3) run_search(0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_START;
		pool_positive = 1'b0;
		reg_pop = 17'd1;
		reg_clu = 17'd1;
		srch_phase = PH_IDLE;
		srch_dense = 1'b0;
		srch_lo = '0;
		srch_hi = '0;
		blk_at = '0;
		blk_first = '0;
		blk_last = '0;
		blk_any = 1'b0;
		edge_left = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_answers();
		test_single_item();
		test_zero_registers();
		test_oversized_restart();
		test_dense_scan();
		test_random_searches(0, 0, 160);
		test_random_searches(83, 0, 160);
		test_random_searches(0, 83, 160);
		test_random_searches(38, 38, 160);
		test_backpressure();

		wait_results_done();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_resp_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
